/* sv/four_wheel_pid_speed_control_assert.svh */
// assertion macros for the four-wheel pid speed controller
`ifndef FOUR_WHEEL_PID_SPEED_CONTROL_ASSERT_SVH
`define FOUR_WHEEL_PID_SPEED_CONTROL_ASSERT_SVH

// same-cycle implication, checked on every clock edge out of reset
`define FWPID_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwpid assertion failed");

// next-cycle implication, checked on every clock edge out of reset
`define FWPID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwpid assertion failed");

`endif

/* sv/fwpid_pkg.sv */
// shared types and constants of the four-wheel pid speed controller
`timescale 1ns / 1ps

package fwpid_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int POS_W      = 32;
    localparam int TGT_W      = 7;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 16;
    localparam int DRV_OUT_W  = 8;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W  = 160;
    localparam int M_TDATA_W  = 32;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_DERIV_GAIN = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } gains_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic s0_load;
        logic s1_load;
        logic s2_load;
        logic s3_load;
    } stage_ctrl_t;

endpackage

/* sv/four_wheel_pid_speed_control.sv */
// top level of the four-wheel pid speed controller: stream ports, gain registers, pipeline control
`timescale 1ns / 1ps

// Four-wheel PID speed controller. Each transfer on the s_ side is one control tick
// carrying four encoder positions and four target speeds; for every tick exactly one
// transfer leaves on the m_ side with the four clamped drive levels, in order. Speed
// is the wrapped position change since the previous tick, the error is target minus
// speed, and the Q8.8 gains weight error, saturating integral and error change; the
// scaled sum is added to the stored drive level, clamped to 0..DRIVE_MAX. One tick is
// accepted every clock cycle unless a stalled output has filled every stage. A tick passes
// four registers (input register, error and integral stage, multiplier stage, sum and
// clamp stage whose register is also the output). Each stage holds its item only while
// the stage after it is full, so empty stages keep taking ticks during output stalls.
// Gains are written over the APB port at 0x0 (prop), 0x4 (integ) and 0x8 (deriv), low
// 16 bits of pwdata; write them only while no tick is in flight.

module four_wheel_pid_speed_control
    import fwpid_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int INTEGRAL_WIDTH = 24,
    parameter int DRIVE_MAX      = 255
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // tick stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // position_front_left, position_front_right, position_rear_left, position_rear_right,
    // target_front_left, target_front_right, target_rear_left, target_rear_right, pad
    input  logic [S_TDATA_W-1:0]  s_tdata,

    // drive stream out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // drive_front_left, drive_front_right, drive_rear_left, drive_rear_right
    output logic [M_TDATA_W-1:0]  m_tdata,

    // gain register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // gain registers
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;
    logic [GAIN_W-1:0] deriv_gain_reg;
    logic              cfg_write;
    logic [1:0]        cfg_idx;
    gains_t            gains;

    // pipeline occupancy, one bit per stage
    logic in_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic ready0, ready1, ready2, ready3;
    stage_ctrl_t ctrl;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_PROP_GAIN:  prop_gain_reg  <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN: integ_gain_reg <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN: deriv_gain_reg <= pwdata[GAIN_W-1:0];
                default:        ;  // unmapped address, write dropped
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_PROP_GAIN:  prdata = CFG_DATA_W'(prop_gain_reg);
            REG_INTEG_GAIN: prdata = CFG_DATA_W'(integ_gain_reg);
            REG_DERIV_GAIN: prdata = CFG_DATA_W'(deriv_gain_reg);
            default:        prdata = '0;
        endcase
    end

    assign gains = '{prop: prop_gain_reg, integ: integ_gain_reg, deriv: deriv_gain_reg};

    // a stage may take a new item when it is empty or its item moves on
    assign ready3 = !out_valid_reg || m_tready;
    assign ready2 = !s2_valid_reg  || ready3;
    assign ready1 = !s1_valid_reg  || ready2;
    assign ready0 = !in_valid_reg  || ready1;

    assign s_tready = ready0;
    assign m_tvalid = out_valid_reg;

    assign ctrl.s0_load = s_tvalid && ready0;
    assign ctrl.s1_load = in_valid_reg && ready1;
    assign ctrl.s2_load = s1_valid_reg && ready2;
    assign ctrl.s3_load = s2_valid_reg && ready3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
                in_valid_reg <= s_tvalid;
            if (ready1)
                s1_valid_reg <= in_valid_reg;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
            if (ready3)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // one datapath per wheel, fields unpacked from the low bits up
    for (genvar w = 0; w < NUM_WHEELS; w++)
    begin : g_wheel
        fwpid_wheel #(
            .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
            .INTEGRAL_WIDTH (INTEGRAL_WIDTH),
            .DRIVE_MAX      (DRIVE_MAX)
        ) u_wheel (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .gains    (gains),
            .position (s_tdata[w*POS_W +: POS_W]),
            .target   (s_tdata[NUM_WHEELS*POS_W + w*TGT_W +: TGT_W]),
            .drive    (m_tdata[w*DRV_OUT_W +: DRV_OUT_W])
        );
    end

    `include "four_wheel_pid_speed_control_assert.svh"

    // a result only appears after an item sat in the multiplier stage
    `FWPID_ASSERT_SAME(a_out_from_s2, $rose(out_valid_reg), $past(s2_valid_reg))
    // a full pipeline behind a stalled output must push back on the input
    `FWPID_ASSERT_SAME(a_full_backpressure,
        out_valid_reg && !m_tready && s2_valid_reg && s1_valid_reg && in_valid_reg, !s_tready)
    // an accepted tick always lands in the input register
    `FWPID_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, in_valid_reg)
    // a stalled result is never overwritten by the stage behind it
    `FWPID_ASSERT_SAME(a_no_overwrite, out_valid_reg && !m_tready, !ctrl.s3_load)

endmodule

/* sv/fwpid_wheel.sv */
// datapath and state of one wheel: error, integral, products, drive level
`timescale 1ns / 1ps

module fwpid_wheel
    import fwpid_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int INTEGRAL_WIDTH = 24,
    parameter int DRIVE_MAX      = 255
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stage_ctrl_t          ctrl,
    input  gains_t               gains,
    input  logic [POS_W-1:0]     position,
    input  logic [TGT_W-1:0]     target,
    output logic [DRV_OUT_W-1:0] drive
);

    localparam int IW     = INTEGRAL_WIDTH;
    localparam int DRV_W  = $clog2(DRIVE_MAX + 1);
    localparam int P_W    = GAIN_W + ERR_W + 1;
    localparam int I_W    = GAIN_W + IW + 1;
    localparam int D_W    = GAIN_W + ERR_W + 2;
    localparam int SUM_W  = ((I_W > D_W) ? I_W : D_W) + 2;

    localparam logic [SUM_W-1:0]   RND_BIAS = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
    localparam logic signed [SUM_W:0] LVL_MAX = (SUM_W + 1)'(DRIVE_MAX);
    localparam logic [IW-1:0]      INT_MAX  = {1'b0, {(IW - 1){1'b1}}};
    localparam logic [IW-1:0]      INT_MIN  = {1'b1, {(IW - 1){1'b0}}};

    // input register
    logic [POS_W-1:0] pos_s0_reg;
    logic [TGT_W-1:0] tgt_s0_reg;

    // per-wheel state
    logic [POS_W-1:0] last_pos_reg;
    logic [IW-1:0]    integ_reg, integ_next;
    logic [ERR_W-1:0] prev_err_reg, err_next;
    logic [DRV_W-1:0] drive_level_reg, drive_level_next;

    // stage 1 and stage 2 data
    logic [ERR_W-1:0]        err_s1_reg;
    logic [IW-1:0]           integ_s1_reg;
    logic [ERR_W:0]          deriv_s1_reg, deriv_next;
    logic signed [P_W-1:0]   p_prod_reg, p_prod_next;
    logic signed [I_W-1:0]   i_prod_reg, i_prod_next;
    logic signed [D_W-1:0]   d_prod_reg, d_prod_next;

    logic [POS_W-1:0]   diff;
    logic [ERR_W-1:0]   speed;
    logic [ERR_W+1:0]   err_wide;
    logic [IW:0]        integ_wide;
    logic signed [SUM_W-1:0] sum, sum_adj, step;
    logic signed [SUM_W:0]   lvl;

    always_ff @(posedge clk)
    begin
        if (ctrl.s0_load)
        begin
            pos_s0_reg <= position;
            tgt_s0_reg <= target;
        end
    end

    // speed, error, integral and derivative
    always_comb
    begin
        diff = pos_s0_reg - last_pos_reg;
        if ((&diff[POS_W-1:ERR_W-1]) || !(|diff[POS_W-1:ERR_W-1]))
            speed = diff[ERR_W-1:0];
        else
            speed = diff[POS_W-1] ? {1'b1, {(ERR_W - 1){1'b0}}} : {1'b0, {(ERR_W - 1){1'b1}}};

        err_wide = {{(ERR_W + 2 - TGT_W){1'b0}}, tgt_s0_reg} - {{2{speed[ERR_W-1]}}, speed};
        if ((&err_wide[ERR_W+1:ERR_W-1]) || !(|err_wide[ERR_W+1:ERR_W-1]))
            err_next = err_wide[ERR_W-1:0];
        else
            err_next = err_wide[ERR_W+1] ? {1'b1, {(ERR_W - 1){1'b0}}}
                                         : {1'b0, {(ERR_W - 1){1'b1}}};

        integ_wide = {integ_reg[IW-1], integ_reg}
                   + {{(IW + 1 - ERR_W){err_next[ERR_W-1]}}, err_next};
        if (integ_wide[IW] == integ_wide[IW-1])
            integ_next = integ_wide[IW-1:0];
        else
            integ_next = integ_wide[IW] ? INT_MIN : INT_MAX;

        deriv_next = {err_next[ERR_W-1], err_next} - {prev_err_reg[ERR_W-1], prev_err_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pos_reg <= '0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end
        else if (ctrl.s1_load)
        begin
            last_pos_reg <= pos_s0_reg;
            integ_reg    <= integ_next;
            prev_err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            err_s1_reg   <= err_next;
            integ_s1_reg <= integ_next;
            deriv_s1_reg <= deriv_next;
        end
    end

    // gain products, gains are unsigned so they get a zero sign bit
    always_comb
    begin
        p_prod_next = $signed({1'b0, gains.prop})  * $signed(err_s1_reg);
        i_prod_next = $signed({1'b0, gains.integ}) * $signed(integ_s1_reg);
        d_prod_next = $signed({1'b0, gains.deriv}) * $signed(deriv_s1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s2_load)
        begin
            p_prod_reg <= p_prod_next;
            i_prod_reg <= i_prod_next;
            d_prod_reg <= d_prod_next;
        end
    end

    // weighted sum, scale toward zero, add to level and clamp
    always_comb
    begin
        sum     = SUM_W'(p_prod_reg) + SUM_W'(i_prod_reg) + SUM_W'(d_prod_reg);
        sum_adj = sum + (sum[SUM_W-1] ? $signed(RND_BIAS) : $signed({SUM_W{1'b0}}));
        step    = sum_adj >>> GAIN_FRAC_BITS;
        lvl     = $signed({step[SUM_W-1], step})
                + $signed({{(SUM_W + 1 - DRV_W){1'b0}}, drive_level_reg});
        if (lvl[SUM_W])
            drive_level_next = '0;
        else if (lvl > LVL_MAX)
            drive_level_next = DRV_W'(DRIVE_MAX);
        else
            drive_level_next = lvl[DRV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drive_level_reg <= '0;
        else if (ctrl.s3_load)
            drive_level_reg <= drive_level_next;
    end

    assign drive = DRV_OUT_W'(drive_level_reg);

endmodule
